[sv/planar_vram_masked_shift_write_macros.svh]
// Assertion macros shared by the planar video memory write unit.
`ifndef PLANAR_VRAM_MASKED_SHIFT_WRITE_MACROS_SVH
`define PLANAR_VRAM_MASKED_SHIFT_WRITE_MACROS_SVH

`ifndef NO_ASSERTIONS

// Condition implies consequence in the same cycle.
`define PVMSW_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pvmsw check failed");

// Condition implies consequence in the next cycle.
`define PVMSW_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pvmsw check failed");

`else

`define PVMSW_ASSERT_NOW(label, ante, cons)
`define PVMSW_ASSERT_NEXT(label, ante, cons)

`endif

`endif

[sv/pvmsw_pkg.sv]
// Shared types and constants of the planar video memory write unit.
package pvmsw_pkg;

    // Fixed field widths.
    localparam int ADDR_W     = 17;
    localparam int DATA_W     = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;
    localparam int MAX_LANES  = 4;
    localparam int LANE_SEL_W = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_SHIFT_AMOUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEEP_LOW     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEEP_HIGH    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_ENABLE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_READ_SELECT  = 3'd4;

    // Access modes.
    typedef enum logic [1:0] {
        MODE_BYTE_WR = 2'd0,
        MODE_WORD_WR = 2'd1,
        MODE_BYTE_RD = 2'd2,
        MODE_WORD_RD = 2'd3
    } mode_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_REDUCE,
        S_EXEC,
        S_WRHI,
        S_FLUSH
    } state_t;

    // Control of one plane lane.
    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic wr_sel;
        logic clear;
    } lane_ctl_t;

    // Byte merged into a plane with its keep mask.
    typedef struct packed {
        logic [7:0] value;
        logic [7:0] keep;
    } wr_byte_t;

endpackage

[sv/pvmsw_addr_mod.sv]
// Reduction of a byte address modulo the plane size by reciprocal multiplication.
module pvmsw_addr_mod #(
    parameter int PLANE_BYTES = 131072
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  logic [pvmsw_pkg::ADDR_W-1:0]          value,
    output logic                                  done,
    output logic [$clog2(PLANE_BYTES)-1:0]        result
);

    localparam int AW    = pvmsw_pkg::ADDR_W;
    localparam int PA_W  = $clog2(PLANE_BYTES);
    localparam int RCP_K = AW + PA_W;
    localparam int RCP_W = AW + 1;
    localparam int PRD_W = AW + RCP_W;
    localparam int BCK_W = AW + PA_W;
    localparam longint unsigned RCP_VAL =
        ((64'd1 << RCP_K) + 64'(PLANE_BYTES) - 64'd1) / 64'(PLANE_BYTES);
    localparam logic [RCP_W-1:0] RECIP = RCP_W'(RCP_VAL);

    logic              calc_q_reg;
    logic              calc_r_reg;
    logic              done_reg;
    logic [AW-1:0]     val_reg;
    logic [AW-1:0]     quot_reg;
    logic [AW-1:0]     quot_next;
    logic [AW-1:0]     rem_reg;
    logic [AW-1:0]     rem_next;
    logic [PRD_W-1:0]  rcp_prod;
    logic [BCK_W-1:0]  back_prod;

    // The reciprocal is exact for every address of the field width.
    assign rcp_prod  = PRD_W'(val_reg) * PRD_W'(RECIP);
    assign quot_next = AW'(rcp_prod >> RCP_K);

    // Remainder from the registered quotient.
    assign back_prod = BCK_W'(quot_reg) * BCK_W'(PLANE_BYTES);
    assign rem_next  = val_reg - back_prod[AW-1:0];

    assign done   = done_reg;
    assign result = PA_W'(rem_reg);

    // Stage markers: quotient, remainder, then done.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            calc_q_reg <= 1'b0;
            calc_r_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            calc_q_reg <= start;
            calc_r_reg <= calc_q_reg;
            done_reg   <= calc_r_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            val_reg <= value;
        end
        if (calc_q_reg)
        begin
            quot_reg <= quot_next;
        end
        if (calc_r_reg)
        begin
            rem_reg <= rem_next;
        end
    end

endmodule

[sv/pvmsw_lane.sv]
// One plane lane: byte memory with two registered reads and a masked merge write.
module pvmsw_lane #(
    parameter int PLANE_BYTES = 131072
) (
    input  logic                              clk,
    input  pvmsw_pkg::lane_ctl_t              ctl,
    input  logic [$clog2(PLANE_BYTES)-1:0]    rd_addr0,
    input  logic [$clog2(PLANE_BYTES)-1:0]    rd_addr1,
    input  logic [$clog2(PLANE_BYTES)-1:0]    wr_addr,
    input  pvmsw_pkg::wr_byte_t               wr_byte,
    output logic [7:0]                        rd_data0,
    output logic [7:0]                        rd_data1
);

    logic [7:0] mem_reg [PLANE_BYTES];
    logic [7:0] rd0_reg;
    logic [7:0] rd1_reg;
    logic [7:0] old_byte;
    logic [7:0] merged;

    // Kept bits come from the byte read earlier at the same address.
    assign old_byte = ctl.wr_sel ? rd1_reg : rd0_reg;
    assign merged   = (old_byte & wr_byte.keep) | (wr_byte.value & ~wr_byte.keep);

    assign rd_data0 = rd0_reg;
    assign rd_data1 = rd1_reg;

    // Memory write port, clearing pass included.
    always_ff @(posedge clk)
    begin
        if (ctl.clear)
        begin
            mem_reg[wr_addr] <= 8'h00;
        end
        else if (ctl.wr_en)
        begin
            mem_reg[wr_addr] <= merged;
        end
    end

    // Two registered read ports.
    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            rd0_reg <= mem_reg[rd_addr0];
            rd1_reg <= mem_reg[rd_addr1];
        end
    end

endmodule

[sv/planar_vram_masked_shift_write.sv]
// Flow: an accepted beat passes the EXEC state, plus the WRHI state for word writes, and
// its result is then loaded into the output register, held in FLUSH while that stalls.
// A new beat is taken only back in IDLE; each plane memory has a single write port, so a
// word write writes its bytes in EXEC and WRHI; addresses at or above PLANE_BYTES first pass the address reducer.
// Reset: a clearing pass over every address zeroes all planes; no beat is taken then.
// Top level of the planar video memory write unit.
`include "planar_vram_masked_shift_write_macros.svh"

module planar_vram_masked_shift_write #(
    parameter int PLANE_BYTES = 131072,
    parameter int PLANE_COUNT = 4
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [pvmsw_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [pvmsw_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [1:0]                           mode,
    input  logic [pvmsw_pkg::ADDR_W-1:0]         address,
    input  logic [pvmsw_pkg::DATA_W-1:0]         write_data,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [pvmsw_pkg::DATA_W-1:0]         read_data
);

    localparam int PA_W  = $clog2(PLANE_BYTES);
    localparam int CW    = ((pvmsw_pkg::ADDR_W > PA_W) ? pvmsw_pkg::ADDR_W : PA_W) + 1;
    localparam int LANES = (PLANE_COUNT < pvmsw_pkg::MAX_LANES) ?
                           PLANE_COUNT : pvmsw_pkg::MAX_LANES;
    localparam logic [PA_W-1:0] CLR_LAST = PA_W'(PLANE_BYTES - 1);

    // Configuration registers.
    logic [3:0]                          shift_reg;
    logic [7:0]                          keep_lo_reg;
    logic [7:0]                          keep_hi_reg;
    logic [3:0]                          plane_en_reg;
    logic [pvmsw_pkg::LANE_SEL_W-1:0]    rsel_reg;

    // Sequencer and item state.
    pvmsw_pkg::state_t                   state_reg;
    pvmsw_pkg::state_t                   state_next;
    pvmsw_pkg::mode_t                    mode_reg;
    logic                                odd_reg;
    logic [7:0]                          latch_lo_reg;
    logic [7:0]                          latch_hi_reg;
    logic [PA_W-1:0]                     a0_reg;
    logic [PA_W-1:0]                     a1_reg;
    logic [PA_W-1:0]                     clr_cnt_reg;
    logic                                out_valid_reg;
    logic [pvmsw_pkg::DATA_W-1:0]        read_data_reg;

    // Control from the sequencer.
    logic                                stall_c;
    logic                                red_start;
    logic                                rd_issue;
    logic                                lane_wr;
    logic                                wr_second;
    logic                                lane_clear;
    logic                                deliver;
    logic                                out_load;
    logic                                out_free;
    logic                                accept;

    // Address path.
    logic                                addr_direct;
    logic                                red_done;
    logic [PA_W-1:0]                     red_result;
    logic [PA_W-1:0]                     a0_src;
    logic [PA_W:0]                       a0_inc;
    logic [PA_W-1:0]                     a1_src;
    logic [PA_W-1:0]                     wr_addr;

    // Write data path.
    logic [31:0]                         shifted;
    logic                                use_hi;
    pvmsw_pkg::wr_byte_t                 wr_byte;

    // Merge stage.
    logic [7:0]                          lane_rd0 [pvmsw_pkg::MAX_LANES];
    logic [7:0]                          lane_rd1 [pvmsw_pkg::MAX_LANES];
    logic [7:0]                          sel_rd0;
    logic [7:0]                          sel_rd1;
    logic [pvmsw_pkg::DATA_W-1:0]        result;

    assign accept    = in_valid && !stall_c;
    assign in_stall  = stall_c;
    assign out_valid = out_valid_reg;
    assign read_data = read_data_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    // Configuration write decoder.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg    <= 4'd0;
            keep_lo_reg  <= 8'd0;
            keep_hi_reg  <= 8'd0;
            plane_en_reg <= 4'd1;
            rsel_reg     <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                pvmsw_pkg::REG_SHIFT_AMOUNT: shift_reg    <= cfg_data[3:0];
                pvmsw_pkg::REG_KEEP_LOW:     keep_lo_reg  <= cfg_data;
                pvmsw_pkg::REG_KEEP_HIGH:    keep_hi_reg  <= cfg_data;
                pvmsw_pkg::REG_PLANE_ENABLE: plane_en_reg <= cfg_data[3:0];
                pvmsw_pkg::REG_READ_SELECT:  rsel_reg     <= cfg_data[1:0];
                default:                     ;
            endcase
        end
    end

    // Address reduction and the neighboring address with wrap.
    assign addr_direct = CW'(address) < CW'(PLANE_BYTES);

    pvmsw_addr_mod #(
        .PLANE_BYTES (PLANE_BYTES)
    ) u_addr_mod (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (red_start),
        .value  (address),
        .done   (red_done),
        .result (red_result)
    );

    assign a0_src = (state_reg == pvmsw_pkg::S_IDLE) ? PA_W'(address) : red_result;
    assign a0_inc = {1'b0, a0_src} + 1'b1;
    assign a1_src = (a0_inc == (PA_W + 1)'(PLANE_BYTES)) ? '0 : a0_inc[PA_W-1:0];

    // Sequencer next state and control.
    always_comb
    begin
        state_next = state_reg;
        stall_c    = 1'b1;
        red_start  = 1'b0;
        rd_issue   = 1'b0;
        lane_wr    = 1'b0;
        wr_second  = 1'b0;
        lane_clear = 1'b0;
        deliver    = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            pvmsw_pkg::S_CLEAR:
            begin
                lane_clear = 1'b1;
                if (clr_cnt_reg == CLR_LAST)
                begin
                    state_next = pvmsw_pkg::S_IDLE;
                end
            end
            pvmsw_pkg::S_IDLE:
            begin
                stall_c = 1'b0;
                if (in_valid)
                begin
                    if (addr_direct)
                    begin
                        rd_issue   = 1'b1;
                        state_next = pvmsw_pkg::S_EXEC;
                    end
                    else
                    begin
                        red_start  = 1'b1;
                        state_next = pvmsw_pkg::S_REDUCE;
                    end
                end
            end
            pvmsw_pkg::S_REDUCE:
            begin
                if (red_done)
                begin
                    rd_issue   = 1'b1;
                    state_next = pvmsw_pkg::S_EXEC;
                end
            end
            pvmsw_pkg::S_EXEC:
            begin
                lane_wr = (mode_reg == pvmsw_pkg::MODE_BYTE_WR) ||
                          (mode_reg == pvmsw_pkg::MODE_WORD_WR);
                if (mode_reg == pvmsw_pkg::MODE_WORD_WR)
                begin
                    state_next = pvmsw_pkg::S_WRHI;
                end
                else
                begin
                    deliver = 1'b1;
                end
            end
            pvmsw_pkg::S_WRHI:
            begin
                lane_wr   = 1'b1;
                wr_second = 1'b1;
                deliver   = 1'b1;
            end
            pvmsw_pkg::S_FLUSH:
            begin
                deliver = 1'b1;
            end
            default:
            begin
                state_next = pvmsw_pkg::S_IDLE;
            end
        endcase
        // Hand the result to the output register, or hold until it frees up.
        if (deliver)
        begin
            if (out_free)
            begin
                out_load   = 1'b1;
                state_next = pvmsw_pkg::S_IDLE;
            end
            else
            begin
                state_next = pvmsw_pkg::S_FLUSH;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= pvmsw_pkg::S_CLEAR;
            clr_cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (lane_clear)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
        end
    end

    // Bus latches load on accepted write beats.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            latch_lo_reg <= 8'h00;
            latch_hi_reg <= 8'h00;
        end
        else if (accept)
        begin
            case (pvmsw_pkg::mode_t'(mode))
                pvmsw_pkg::MODE_BYTE_WR:
                begin
                    if (address[0])
                    begin
                        latch_hi_reg <= write_data[7:0];
                    end
                    else
                    begin
                        latch_lo_reg <= write_data[7:0];
                    end
                end
                pvmsw_pkg::MODE_WORD_WR:
                begin
                    if (address[0])
                    begin
                        latch_lo_reg <= write_data[15:8];
                        latch_hi_reg <= write_data[7:0];
                    end
                    else
                    begin
                        latch_lo_reg <= write_data[7:0];
                        latch_hi_reg <= write_data[15:8];
                    end
                end
                default: ;
            endcase
        end
    end

    // Item payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg <= pvmsw_pkg::mode_t'(mode);
            odd_reg  <= address[0];
        end
        if (rd_issue)
        begin
            a0_reg <= a0_src;
            a1_reg <= a1_src;
        end
    end

    // Replicated latch word, shifted; the parity picks the byte and its mask.
    assign shifted       = {latch_hi_reg, latch_lo_reg, latch_hi_reg, latch_lo_reg} >> shift_reg;
    assign use_hi        = odd_reg ^ wr_second;
    assign wr_byte.value = use_hi ? shifted[15:8] : shifted[7:0];
    assign wr_byte.keep  = use_hi ? keep_hi_reg : keep_lo_reg;
    assign wr_addr       = lane_clear ? clr_cnt_reg : (wr_second ? a1_reg : a0_reg);

    // Plane lanes side by side; missing planes read as zero.
    for (genvar p = 0; p < pvmsw_pkg::MAX_LANES; p++)
    begin : g_lane
        if (p < LANES)
        begin : g_on
            pvmsw_pkg::lane_ctl_t ctl;

            assign ctl.rd_en  = rd_issue;
            assign ctl.wr_en  = lane_wr && plane_en_reg[p];
            assign ctl.wr_sel = wr_second;
            assign ctl.clear  = lane_clear;

            pvmsw_lane #(
                .PLANE_BYTES (PLANE_BYTES)
            ) u_lane (
                .clk      (clk),
                .ctl      (ctl),
                .rd_addr0 (a0_src),
                .rd_addr1 (a1_src),
                .wr_addr  (wr_addr),
                .wr_byte  (wr_byte),
                .rd_data0 (lane_rd0[p]),
                .rd_data1 (lane_rd1[p])
            );
        end
        else
        begin : g_off
            assign lane_rd0[p] = 8'h00;
            assign lane_rd1[p] = 8'h00;
        end
    end

    // Merge stage: pick the selected plane and form the result.
    assign sel_rd0 = lane_rd0[rsel_reg];
    assign sel_rd1 = lane_rd1[rsel_reg];

    always_comb
    begin
        case (mode_reg)
            pvmsw_pkg::MODE_BYTE_RD: result = {8'h00, sel_rd0};
            pvmsw_pkg::MODE_WORD_RD: result = {sel_rd1, sel_rd0};
            default:                 result = '0;
        endcase
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            read_data_reg <= result;
        end
    end

    // Checks on the sequencer.
    `PVMSW_ASSERT_NOW(a_no_accept_in_clear, state_reg == pvmsw_pkg::S_CLEAR, in_stall)
    `PVMSW_ASSERT_NEXT(a_accept_leaves_idle, in_valid && !in_stall,
                       state_reg != pvmsw_pkg::S_IDLE)
    `PVMSW_ASSERT_NEXT(a_word_write_second,
                       (state_reg == pvmsw_pkg::S_EXEC) &&
                       (mode_reg == pvmsw_pkg::MODE_WORD_WR),
                       state_reg == pvmsw_pkg::S_WRHI)
    `PVMSW_ASSERT_NOW(a_load_needs_room, out_load, !out_valid_reg || !out_stall)

endmodule
